// File: rtl/core/srnp_pkg.sv
`timescale 1ns / 1ps
// Package for the signed radix number parser.
// Holds character constants, the digit decode function and the shared structs.
package srnp_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned RadixW = 6;
  localparam int unsigned DigitW = 7;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CountW = 8;

  localparam logic [RadixW-1:0] RadixReset = RadixW'(10);
  localparam logic [RadixW-1:0] RadixMax = RadixW'(36);
  localparam logic [DigitW-1:0] NoDigit = DigitW'(99);
  localparam logic [DigitW-1:0] LetterBase = DigitW'(10);

  localparam logic [CharW-1:0] ChZero = 8'h30;
  localparam logic [CharW-1:0] ChNine = 8'h39;
  localparam logic [CharW-1:0] ChUpperA = 8'h41;
  localparam logic [CharW-1:0] ChUpperZ = 8'h5A;
  localparam logic [CharW-1:0] ChLowerA = 8'h61;
  localparam logic [CharW-1:0] ChLowerZ = 8'h7A;
  localparam logic [CharW-1:0] ChPlus = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] CaseOffset = 8'h20;

  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic              is_sign;
    logic              is_minus;
  } digit_info_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [CountW-1:0] count;
    logic              bad_base;
  } result_t;

  function automatic logic [DigitW-1:0] digit_of(input logic [CharW-1:0] ch);
    logic [CharW-1:0] up;
    logic [CharW-1:0] diff;
    up = ch;
    if (ch >= ChLowerA && ch <= ChLowerZ) begin
      up = ch - CaseOffset;
    end
    if (up >= ChZero && up <= ChNine) begin
      diff = up - ChZero;
      digit_of = diff[DigitW-1:0];
    end else if (up >= ChUpperA && up <= ChUpperZ) begin
      diff = up - ChUpperA;
      digit_of = diff[DigitW-1:0] + LetterBase;
    end else begin
      digit_of = NoDigit;
    end
  endfunction

endpackage

// File: rtl/core/srnp_decode.sv
`timescale 1ns / 1ps
// Character decoder: digit value and sign detection for one registered character.
// Depends on srnp_pkg.
module srnp_decode import srnp_pkg::*; (
  input  logic [CharW-1:0] char_i,
  output digit_info_t      info_o
);

  always_comb begin
    info_o.digit    = digit_of(char_i);
    info_o.is_sign  = (char_i == ChPlus) || (char_i == ChMinus);
    info_o.is_minus = (char_i == ChMinus);
  end

endmodule

// File: rtl/core/srnp_accum.sv
`timescale 1ns / 1ps
// Token state and multiply-accumulate: updates the accumulator, sign and count
// for one decoded character and forms the result word. Depends on srnp_pkg.
module srnp_accum import srnp_pkg::*; #(
  parameter logic [CountW-1:0] CountCap = 8'd255
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              first_i,
  input  logic              last_i,
  input  digit_info_t       info_i,
  input  logic [RadixW-1:0] radix_i,
  output result_t           result_o
);

  logic [ValueW-1:0] acc_q, acc_d, acc_b;
  logic              neg_q, neg_d, neg_b;
  logic              stop_q, stop_d, stop_b;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_b, cnt_inc;
  logic              radix_ok, sign_step, take_digit;
  logic [ValueW-1:0] product;

  assign radix_ok = (radix_i != '0) && (radix_i <= RadixMax);
  assign sign_step = first_i && info_i.is_sign;
  assign take_digit = radix_ok && (info_i.digit < {1'b0, radix_i});

  always_comb begin
    acc_b  = first_i ? '0 : acc_q;
    neg_b  = first_i ? sign_step && info_i.is_minus : neg_q;
    stop_b = first_i ? 1'b0 : stop_q;
    cnt_b  = first_i ? '0 : cnt_q;
  end

  assign cnt_inc = (cnt_b < CountCap) ? cnt_b + CountW'(1) : cnt_b;
  assign product = acc_b * {{(ValueW-RadixW){1'b0}}, radix_i}
                 + {{(ValueW-DigitW){1'b0}}, info_i.digit};

  always_comb begin
    acc_d  = acc_b;
    neg_d  = neg_b;
    stop_d = stop_b;
    cnt_d  = cnt_b;
    if (!sign_step) begin
      if (stop_b) begin
        cnt_d = cnt_inc;
      end else if (take_digit) begin
        acc_d = product;
      end else begin
        stop_d = 1'b1;
        cnt_d  = cnt_inc;
      end
    end
    result_o.bad_base = !radix_ok;
    result_o.count    = cnt_d;
    if (!radix_ok) begin
      result_o.value = '0;
    end else if (neg_d) begin
      result_o.value = '0 - acc_d;
    end else begin
      result_o.value = acc_d;
    end
    if (last_i) begin
      acc_d  = '0;
      neg_d  = 1'b0;
      stop_d = 1'b0;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      neg_q  <= 1'b0;
      stop_q <= 1'b0;
      cnt_q  <= '0;
    end else if (step_i) begin
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      stop_q <= stop_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// File: rtl/core/signed_radix_number_parser.sv
`timescale 1ns / 1ps
// Signed radix number parser top level: input word register, decoder,
// accumulator and result register. Depends on srnp_pkg, srnp_decode, srnp_accum.
// A word updates the token state as it leaves the input register; a last character
// also loads its result, and waits there while the result register is not yet taken.
// Throughput: one word per cycle except during that wait, set by the combinational MAC.
// Reset clears the token state, empties both registers and sets the radix to 10.
module signed_radix_number_parser import srnp_pkg::*; #(
  parameter int unsigned MaxTokenChars = 255
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     radix_we_i,
  input  logic [RadixW-1:0]        radix_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CharW-1:0]         character_i,
  input  logic                     first_char_i,
  input  logic                     last_char_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ValueW-1:0] value_o,
  output logic [CountW-1:0]        unconverted_count_o,
  output logic                     base_invalid_o
);

  localparam int unsigned CapInt = (MaxTokenChars > 255) ? 255 : MaxTokenChars;
  localparam logic [CountW-1:0] CountCap = CountW'(CapInt);

  logic [RadixW-1:0] radix_q;
  logic              s1_valid_q;
  logic [CharW-1:0]  s1_char_q;
  logic              s1_first_q, s1_last_q;
  logic              out_valid_q;
  result_t           out_q;
  logic              out_free, s1_go, step, load_out, in_acc;
  digit_info_t       info;
  result_t           result;

  assign out_free = !out_valid_q || out_ready_i;
  assign s1_go = !s1_last_q || out_free;
  assign step = s1_valid_q && s1_go;
  assign load_out = step && s1_last_q;
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_acc = in_valid_i && in_ready_o;

  srnp_decode u_decode (
    .char_i (s1_char_q),
    .info_o (info)
  );

  srnp_accum #(
    .CountCap (CountCap)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .first_i  (s1_first_q),
    .last_i   (s1_last_q),
    .info_i   (info),
    .radix_i  (radix_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= RadixReset;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (radix_we_i) begin
        radix_q <= radix_i;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_char_q  <= character_i;
      s1_first_q <= first_char_i;
      s1_last_q  <= last_char_i;
    end
    if (load_out) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o = signed'(out_q.value);
  assign unconverted_count_o = out_q.count;
  assign base_invalid_o = out_q.bad_base;

endmodule
